// ===== rtl/qalu_pkg.sv =====
// Shared types, constants and arithmetic helpers for the quaternion ALU.
package qalu_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   localparam int OPND_W     = DATA_WIDTH + 1;
   localparam int PROD_W     = 2 * OPND_W;
   localparam int TRUNC_W    = PROD_W - FRAC_BITS;
   localparam int SUM_W      = TRUNC_W + 2;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_CONJ  = 3'd3,
      OP_ROT   = 3'd4,
      OP_SCALE = 3'd5,
      OP_MAGSQ = 3'd6
   } op_type;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [OPND_W-1:0]     opnd_type;
   typedef logic signed [TRUNC_W-1:0]    trunc_type;
   typedef logic signed [SUM_W-1:0]      sum_type;

   localparam data_type DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [2:0] op;
      data_type   a_w;
      data_type   a_x;
      data_type   a_y;
      data_type   a_z;
      data_type   b_w;
      data_type   b_x;
      data_type   b_y;
      data_type   b_z;
   } req_type;

   typedef struct packed {
      data_type r_w;
      data_type r_x;
      data_type r_y;
      data_type r_z;
      logic     overflow;
   } rsp_type;

   typedef struct packed {
      data_type w;
      data_type x;
      data_type y;
      data_type z;
   } quat_type;

   typedef struct packed {
      opnd_type w;
      opnd_type x;
      opnd_type y;
      opnd_type z;
   } opnd_quat_type;

   typedef struct packed {
      sum_type w;
      sum_type x;
      sum_type y;
      sum_type z;
   } sum_quat_type;

   // travels beside the products; b carries the first result after stage two
   typedef struct packed {
      op_type   op;
      quat_type a;
      quat_type b;
      logic     ovf;
   } side_type;

   // prod[i][j] = floor(p_i * q_j / 2^FRAC_BITS), index 0..3 = w,x,y,z
   typedef trunc_type prod_array_type [4][4];

   function automatic sum_type ext(input data_type v);
      return sum_type'(v);
   endfunction

   function automatic sum_quat_type ham_sum(input prod_array_type pr);
      sum_quat_type s;
      s.w = sum_type'(pr[0][0]) - sum_type'(pr[1][1]) - sum_type'(pr[2][2])
            - sum_type'(pr[3][3]);
      s.x = sum_type'(pr[0][1]) + sum_type'(pr[1][0]) + sum_type'(pr[2][3])
            - sum_type'(pr[3][2]);
      s.y = sum_type'(pr[0][2]) - sum_type'(pr[1][3]) + sum_type'(pr[2][0])
            + sum_type'(pr[3][1]);
      s.z = sum_type'(pr[0][3]) + sum_type'(pr[1][2]) - sum_type'(pr[2][1])
            + sum_type'(pr[3][0]);
      return s;
   endfunction

   function automatic data_type sat_val(input sum_type v);
      data_type r;
      if (v > sum_type'(DMAX)) begin
         r = DMAX;
      end else if (v < sum_type'(DMIN)) begin
         r = DMIN;
      end else begin
         r = v[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic sat_hit(input sum_type v);
      return (v > sum_type'(DMAX)) || (v < sum_type'(DMIN));
   endfunction

endpackage

// ===== rtl/quaternion_alu.sv =====
// Quaternion ALU top level: four-stage pipeline of product and sum stages.
//
//  channel   ports                     direction  handshake
//  request   start, busy, req_data     in         taken when start && !busy
//  response  rsp_strobe, rsp_data      out        one cycle, strobe marks it
//
// Every op takes the same path: product, sum, product, sum/saturate.
// One request per cycle is sustained outside reset; the depth is set by the rotation's
// two chained Hamilton products, each a 16-multiplier stage plus a sum stage.
// busy is high only while reset is high; reset empties the pipeline.
// Responses cannot be held off, so nothing in the pipeline ever waits.
module quaternion_alu
   import qalu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic           accept;
   op_type         op;
   side_type       side0;
   opnd_quat_type  p0;
   opnd_quat_type  q0;
   logic           v1;
   prod_array_type prod1;
   side_type       side1;
   logic           v2;
   side_type       side2;
   opnd_quat_type  p2;
   opnd_quat_type  q2;
   logic           v3;
   prod_array_type prod3;
   side_type       side3;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign op     = op_type'(req_data.op);

   always_comb begin
      side0.op  = op;
      side0.a   = '{w: req_data.a_w, x: req_data.a_x, y: req_data.a_y, z: req_data.a_z};
      side0.b   = '{w: req_data.b_w, x: req_data.b_x, y: req_data.b_y, z: req_data.b_z};
      side0.ovf = 1'b0;

      p0.w = opnd_type'(req_data.a_w);
      p0.x = opnd_type'(req_data.a_x);
      p0.y = opnd_type'(req_data.a_y);
      p0.z = opnd_type'(req_data.a_z);
      if (op == OP_MAGSQ) begin
         q0 = p0;
      end else begin
         q0.w = (op == OP_ROT) ? '0 : opnd_type'(req_data.b_w);
         q0.x = opnd_type'(req_data.b_x);
         q0.y = opnd_type'(req_data.b_y);
         q0.z = opnd_type'(req_data.b_z);
      end
   end

   qalu_mul u_mul1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .p        (p0),
      .q        (q0),
      .side_in  (side0),
      .out_valid(v1),
      .prod     (prod1),
      .side_out (side1)
   );

   qalu_first u_first (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1),
      .prod     (prod1),
      .side_in  (side1),
      .out_valid(v2),
      .side_out (side2)
   );

   // t * conj(a); negated components keep the extra bit
   always_comb begin
      p2.w = opnd_type'(side2.b.w);
      p2.x = opnd_type'(side2.b.x);
      p2.y = opnd_type'(side2.b.y);
      p2.z = opnd_type'(side2.b.z);
      q2.w = opnd_type'(side2.a.w);
      q2.x = -opnd_type'(side2.a.x);
      q2.y = -opnd_type'(side2.a.y);
      q2.z = -opnd_type'(side2.a.z);
   end

   qalu_mul u_mul2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v2),
      .p        (p2),
      .q        (q2),
      .side_in  (side2),
      .out_valid(v3),
      .prod     (prod3),
      .side_out (side3)
   );

   qalu_final u_final (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3),
      .prod     (prod3),
      .side_in  (side3),
      .out_valid(rsp_strobe),
      .rsp      (rsp_data)
   );

endmodule

// ===== rtl/qalu_mul.sv =====
// Product stage: all sixteen truncated cross products of two quaternions, registered.
module qalu_mul
   import qalu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  opnd_quat_type  p,
   input  opnd_quat_type  q,
   input  side_type       side_in,
   output logic           out_valid,
   output prod_array_type prod,
   output side_type       side_out
);

   logic                     valid_ff;
   prod_array_type           prod_ff;
   prod_array_type           prod_in;
   side_type                 side_ff;
   opnd_type                 pv [4];
   opnd_type                 qv [4];
   logic signed [PROD_W-1:0] full [4][4];

   always_comb begin
      pv[0] = p.w;
      pv[1] = p.x;
      pv[2] = p.y;
      pv[3] = p.z;
      qv[0] = q.w;
      qv[1] = q.x;
      qv[2] = q.y;
      qv[3] = q.z;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            full[i][j]    = PROD_W'(pv[i]) * PROD_W'(qv[j]);
            // dropping low bits of two's complement is floor division
            prod_in[i][j] = full[i][j][PROD_W-1:FRAC_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      side_ff <= side_in;
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;
   assign side_out  = side_ff;

endmodule

// ===== rtl/qalu_first.sv =====
// First sum stage: per-op combination of products or inputs, saturated and registered.
module qalu_first
   import qalu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  prod_array_type prod,
   input  side_type       side_in,
   output logic           out_valid,
   output side_type       side_out
);

   logic         valid_ff;
   side_type     sat_side_ff;
   side_type     sat_side_in;
   sum_quat_type ham;
   sum_quat_type v;

   always_comb begin
      ham = ham_sum(prod);
      v   = '0;
      unique case (side_in.op)
         OP_ADD: begin
            v.w = ext(side_in.a.w) + ext(side_in.b.w);
            v.x = ext(side_in.a.x) + ext(side_in.b.x);
            v.y = ext(side_in.a.y) + ext(side_in.b.y);
            v.z = ext(side_in.a.z) + ext(side_in.b.z);
         end
         OP_SUB: begin
            v.w = ext(side_in.a.w) - ext(side_in.b.w);
            v.x = ext(side_in.a.x) - ext(side_in.b.x);
            v.y = ext(side_in.a.y) - ext(side_in.b.y);
            v.z = ext(side_in.a.z) - ext(side_in.b.z);
         end
         OP_MUL, OP_ROT: begin
            v = ham;
         end
         OP_CONJ: begin
            v.w = ext(side_in.a.w);
            v.x = -ext(side_in.a.x);
            v.y = -ext(side_in.a.y);
            v.z = -ext(side_in.a.z);
         end
         OP_SCALE: begin
            v.w = sum_type'(prod[0][0]);
            v.x = sum_type'(prod[1][0]);
            v.y = sum_type'(prod[2][0]);
            v.z = sum_type'(prod[3][0]);
         end
         OP_MAGSQ: begin
            v.w = sum_type'(prod[0][0]) + sum_type'(prod[1][1])
                  + sum_type'(prod[2][2]) + sum_type'(prod[3][3]);
         end
         default: begin
            v = '0;
         end
      endcase

      sat_side_in.op  = side_in.op;
      sat_side_in.a   = side_in.a;
      sat_side_in.b.w = sat_val(v.w);
      sat_side_in.b.x = sat_val(v.x);
      sat_side_in.b.y = sat_val(v.y);
      sat_side_in.b.z = sat_val(v.z);
      sat_side_in.ovf = sat_hit(v.w) | sat_hit(v.x) | sat_hit(v.y) | sat_hit(v.z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sat_side_ff <= sat_side_in;
   end

   assign out_valid = valid_ff;
   assign side_out  = sat_side_ff;

endmodule

// ===== rtl/qalu_final.sv =====
// Final sum stage: second rotation product summed and saturated, other ops passed through; output register.
module qalu_final
   import qalu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  prod_array_type prod,
   input  side_type       side_in,
   output logic           out_valid,
   output rsp_type        rsp
);

   logic         valid_ff;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   sum_quat_type ham;

   always_comb begin
      ham = ham_sum(prod);
      if (side_in.op == OP_ROT) begin
         rsp_in.r_w      = '0;
         rsp_in.r_x      = sat_val(ham.x);
         rsp_in.r_y      = sat_val(ham.y);
         rsp_in.r_z      = sat_val(ham.z);
         rsp_in.overflow = side_in.ovf | sat_hit(ham.x) | sat_hit(ham.y)
                           | sat_hit(ham.z);
      end else begin
         rsp_in.r_w      = side_in.b.w;
         rsp_in.r_x      = side_in.b.x;
         rsp_in.r_y      = side_in.b.y;
         rsp_in.r_z      = side_in.b.z;
         rsp_in.overflow = side_in.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/qalu_checker.sv =====
// Port-level assertions for the quaternion ALU and their bind.
module qalu_checker
   import qalu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_busy_only_in_reset: assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy high outside reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("request without response after four cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("response without matching request");

   a_magsq_shape: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_MAGSQ) |-> ##4
      (rsp_data.r_x == '0 && rsp_data.r_y == '0 && rsp_data.r_z == '0
       && !rsp_data.r_w[DATA_WIDTH-1]))
      else $error("squared magnitude response malformed");

endmodule

bind quaternion_alu qalu_checker u_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_alu: directed corners plus random requests.
module tb_top;
   import qalu_pkg::*;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int Q_ONE = 1 << FRAC_BITS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam longint D_HI = (longint'(1) << (DATA_WIDTH - 1)) - 1;
   localparam longint D_LO = -D_HI - 1;

   typedef struct {
      longint w;
      longint x;
      longint y;
      longint z;
   } wide_quat_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type expected_rsp[$];
   int      err_count = 0;
   int      burst_left = 0;
   int      stall_cycles = 0;

   quaternion_alu u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // fixed-point product, fraction bits dropped toward minus infinity
   function automatic longint fx_mul(input longint p, input longint q);
      return (p * q) >>> FRAC_BITS;
   endfunction

   function automatic longint clamp_data(input longint v, inout bit ovf);
      if (v > D_HI) begin
         ovf = 1'b1;
         return D_HI;
      end
      if (v < D_LO) begin
         ovf = 1'b1;
         return D_LO;
      end
      return v;
   endfunction

   function automatic wide_quat_type clamp_quat(input wide_quat_type v, inout bit ovf);
      wide_quat_type r;
      r.w = clamp_data(v.w, ovf);
      r.x = clamp_data(v.x, ovf);
      r.y = clamp_data(v.y, ovf);
      r.z = clamp_data(v.z, ovf);
      return r;
   endfunction

   function automatic wide_quat_type ham_prod(input wide_quat_type p,
                                              input wide_quat_type q);
      wide_quat_type r;
      r.w = fx_mul(p.w, q.w) - fx_mul(p.x, q.x) - fx_mul(p.y, q.y) - fx_mul(p.z, q.z);
      r.x = fx_mul(p.w, q.x) + fx_mul(p.x, q.w) + fx_mul(p.y, q.z) - fx_mul(p.z, q.y);
      r.y = fx_mul(p.w, q.y) - fx_mul(p.x, q.z) + fx_mul(p.y, q.w) + fx_mul(p.z, q.x);
      r.z = fx_mul(p.w, q.z) + fx_mul(p.x, q.y) - fx_mul(p.y, q.x) + fx_mul(p.z, q.w);
      return r;
   endfunction

   function automatic rsp_type quat_op_result(input req_type q);
      wide_quat_type a, b, r, t, c;
      bit            ovf;
      rsp_type       res;
      ovf = 1'b0;
      a.w = q.a_w; a.x = q.a_x; a.y = q.a_y; a.z = q.a_z;
      b.w = q.b_w; b.x = q.b_x; b.y = q.b_y; b.z = q.b_z;
      r.w = 0; r.x = 0; r.y = 0; r.z = 0;
      unique case (q.op)
         OP_ADD: begin
            r.w = a.w + b.w; r.x = a.x + b.x; r.y = a.y + b.y; r.z = a.z + b.z;
            r = clamp_quat(r, ovf);
         end
         OP_SUB: begin
            r.w = a.w - b.w; r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
            r = clamp_quat(r, ovf);
         end
         OP_MUL: begin
            r = clamp_quat(ham_prod(a, b), ovf);
         end
         OP_CONJ: begin
            r.w = a.w; r.x = -a.x; r.y = -a.y; r.z = -a.z;
            r = clamp_quat(r, ovf);
         end
         OP_ROT: begin
            t.w = 0; t.x = b.x; t.y = b.y; t.z = b.z;
            t = clamp_quat(ham_prod(a, t), ovf);
            c.w = a.w; c.x = -a.x; c.y = -a.y; c.z = -a.z;
            r = ham_prod(t, c);
            r.w = 0;
            r.x = clamp_data(r.x, ovf);
            r.y = clamp_data(r.y, ovf);
            r.z = clamp_data(r.z, ovf);
         end
         OP_SCALE: begin
            r.w = fx_mul(a.w, b.w); r.x = fx_mul(a.x, b.w);
            r.y = fx_mul(a.y, b.w); r.z = fx_mul(a.z, b.w);
            r = clamp_quat(r, ovf);
         end
         OP_MAGSQ: begin
            r.w = clamp_data(fx_mul(a.x, a.x) + fx_mul(a.y, a.y) + fx_mul(a.z, a.z)
                             + fx_mul(a.w, a.w), ovf);
         end
         default: begin
         end
      endcase
      res.r_w = data_type'(r.w);
      res.r_x = data_type'(r.x);
      res.r_y = data_type'(r.y);
      res.r_z = data_type'(r.z);
      res.overflow = ovf;
      return res;
   endfunction

   function automatic req_type mk_req(input logic [2:0] op,
                                      input int aw, input int ax, input int ay, input int az,
                                      input int bw, input int bx, input int by, input int bz);
      req_type r;
      r.op = op;
      r.a_w = data_type'(aw); r.a_x = data_type'(ax);
      r.a_y = data_type'(ay); r.a_z = data_type'(az);
      r.b_w = data_type'(bw); r.b_x = data_type'(bx);
      r.b_y = data_type'(by); r.b_z = data_type'(bz);
      return r;
   endfunction

   function automatic data_type rand_in(input int lim);
      return data_type'(int'($urandom_range(2 * lim)) - lim);
   endfunction

   function automatic req_type rand_full_req();
      return mk_req(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
   endfunction

   function automatic quat_type rand_unit_quat();
      real      c[4];
      real      n;
      quat_type u;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         c[i] = real'(int'($urandom_range(2000)) - 1000);
         n = n + c[i] * c[i];
      end
      if (n == 0.0) begin
         c[0] = 1.0;
         n = 1.0;
      end
      n = $sqrt(n);
      u.w = data_type'(int'(c[0] / n * Q_ONE));
      u.x = data_type'(int'(c[1] / n * Q_ONE));
      u.y = data_type'(int'(c[2] / n * Q_ONE));
      u.z = data_type'(int'(c[3] / n * Q_ONE));
      return u;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (err_count < 50) begin
         $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
      end
      err_count++;
   endtask

   // random bursts with random gaps; garbage on the bus while start is low
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80) : $urandom_range(12);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            start <= 1'b0;
            req_data <= rand_full_req();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_req(input req_type r);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected_rsp.push_back(quat_op_result(r));
      pace_sender();
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_req(mk_req(OP_ADD, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX));
      send_req(mk_req(OP_ADD, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN));
      send_req(mk_req(OP_ADD, Q_ONE, -Q_ONE, 3, -7, 100, 200, -300, 7));
      send_req(mk_req(OP_SUB, DMAX, DMAX, DMIN, 0, DMIN, DMIN, DMAX, 0));
      send_req(mk_req(OP_SUB, DMIN, 0, DMAX, -1, DMAX, 1, DMIN, DMAX));
      send_req(mk_req(OP_MUL, Q_ONE, 0, 0, 0, 1234, -5678, 910, -1112));
      send_req(mk_req(OP_MUL, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX));
      send_req(mk_req(OP_MUL, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN));
      send_req(mk_req(OP_MUL, -1, 0, 0, 0, 1, 0, 0, 0));
      send_req(mk_req(OP_CONJ, DMIN, DMIN, DMIN, DMIN, 0, 0, 0, 0));
      send_req(mk_req(OP_CONJ, DMAX, DMAX, -5, 5, DMIN, DMAX, 1, -1));
      send_req(mk_req(OP_ROT, Q_ONE, 0, 0, 0, DMAX, Q_ONE, -Q_ONE, 2 * Q_ONE));
      send_req(mk_req(OP_ROT, 2896, 0, 0, 2896, 0, Q_ONE, 0, 0));
      send_req(mk_req(OP_ROT, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX));
      send_req(mk_req(OP_ROT, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN));
      send_req(mk_req(OP_SCALE, 1000, -2000, 3000, -4000, Q_ONE, 0, 0, 0));
      send_req(mk_req(OP_SCALE, DMAX, DMIN, DMAX, DMIN, DMAX, 0, 0, 0));
      send_req(mk_req(OP_SCALE, DMIN, DMIN, DMIN, DMIN, DMIN, 0, 0, 0));
      send_req(mk_req(OP_SCALE, -1, 1, -3, 3, 1, 0, 0, 0));
      send_req(mk_req(OP_MAGSQ, DMAX, DMAX, DMAX, DMAX, 0, 0, 0, 0));
      send_req(mk_req(OP_MAGSQ, Q_ONE, 0, 0, 0, DMAX, DMAX, DMAX, DMAX));
      send_req(mk_req(OP_MAGSQ, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN));
      send_req(mk_req(OP_UNUSED, DMAX, DMIN, DMAX, DMIN, DMAX, DMIN, DMAX, DMIN));
      send_req(mk_req(OP_UNUSED, -1, -1, -1, -1, -1, -1, -1, -1));
      send_req(mk_req(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0));
      drain_pipeline();
   endtask

   task automatic test_full_range();
      repeat (250) send_req(rand_full_req());
      drain_pipeline();
   endtask

   // mostly unit quaternions rotating or multiplying modest vectors
   task automatic test_unit_rotation();
      quat_type u, v;
      req_type  r;
      repeat (200) begin
         if ($urandom_range(7) == 0) begin
            r = rand_full_req();
         end else begin
            u = rand_unit_quat();
            v = rand_unit_quat();
            r.op = ($urandom_range(3) == 0) ? OP_MUL : OP_ROT;
            r.a_w = u.w; r.a_x = u.x; r.a_y = u.y; r.a_z = u.z;
            if (r.op == OP_MUL) begin
               r.b_w = v.w; r.b_x = v.x; r.b_y = v.y; r.b_z = v.z;
            end else begin
               r.b_w = data_type'($urandom);
               r.b_x = rand_in(8000); r.b_y = rand_in(8000); r.b_z = rand_in(8000);
            end
         end
         send_req(r);
      end
      drain_pipeline();
   endtask

   task automatic test_mid_range();
      req_type r;
      for (int i = 0; i < 280; i++) begin
         r = mk_req(($urandom_range(15) == 0) ? OP_UNUSED : 3'($urandom_range(6)),
                    rand_in(8192), rand_in(8192), rand_in(8192), rand_in(8192),
                    rand_in(8192), rand_in(8192), rand_in(8192), rand_in(8192));
         send_req(r);
         if (i == 140) begin
            drain_pipeline();
         end
      end
      drain_pipeline();
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (rsp_strobe === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response r_w", rsp_data.r_w, 0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.r_w !== want.r_w) report_mismatch("r_w", rsp_data.r_w, want.r_w);
            if (rsp_data.r_x !== want.r_x) report_mismatch("r_x", rsp_data.r_x, want.r_x);
            if (rsp_data.r_y !== want.r_y) report_mismatch("r_y", rsp_data.r_y, want.r_y);
            if (rsp_data.r_z !== want.r_z) report_mismatch("r_z", rsp_data.r_z, want.r_z);
            if (rsp_data.overflow !== want.overflow) begin
               report_mismatch("overflow", rsp_data.overflow, want.overflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("quaternion_alu test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_range();
      test_unit_rotation();
      test_mid_range();
      repeat (8) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         report_mismatch("responses missing", 0, expected_rsp.size());
      end
      if (err_count == 0) begin
         $display("quaternion_alu test passed");
      end else begin
         $display("quaternion_alu test failed");
      end
      $finish;
   end

endmodule

// ===== quaternion_alu.f =====
rtl/qalu_pkg.sv
rtl/qalu_mul.sv
rtl/qalu_first.sv
rtl/qalu_final.sv
rtl/quaternion_alu.sv
rtl/qalu_checker.sv
verif/tb_top.sv
